FILE: rtl/chunked_segmented_prefix_sum_core_macros.svh
// Assertion helpers used by the prefix-sum core.
`ifndef CHUNKED_SEGMENTED_PREFIX_SUM_CORE_MACROS_SVH
`define CHUNKED_SEGMENTED_PREFIX_SUM_CORE_MACROS_SVH

// Property that holds at every clock edge outside reset.
`define CSPS_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("assertion failed");

// Condition in one cycle implies a consequence in the next.
`define CSPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/csps_pkg.sv
`default_nettype none
package csps_pkg;

  // Defaults and reset values
  localparam int unsigned MaxHeadsDef = 64;
  localparam logic [15:0] ChunkReset  = 16'd64;
  localparam logic [6:0]  HeadsReset  = 7'd1;

  // Register indexes (byte address / 4)
  typedef enum logic [1:0] {
    REG_CHUNK = 2'd0,
    REG_HEADS = 2'd1,
    REG_BF16  = 2'd2,
    REG_NONE  = 2'd3
  } reg_idx_e;

  // fp32 constants
  localparam logic [31:0] FpZero    = 32'h0000_0000;
  localparam logic [31:0] FpDefNan  = 32'hFFC0_0000;
  localparam logic [31:0] FpQuietBit = 32'h0040_0000;
  localparam logic [7:0]  FpExpMax  = 8'hFF;

  // Adder stage after operand swap
  typedef struct packed {
    logic        spec;
    logic [31:0] spec_val;
    logic        sign;
    logic        sub;
    logic [7:0]  exp;
    logic [23:0] mant_l;
    logic [23:0] mant_s;
    logic [7:0]  diff;
  } fadd_swap_t;

  // Adder stage after add
  typedef struct packed {
    logic        spec;
    logic [31:0] spec_val;
    logic        sign;
    logic        sub;
    logic [7:0]  exp;
    logic [27:0] sum;
  } fadd_sum_t;

  // Adder stage after normalization
  typedef struct packed {
    logic        spec;
    logic [31:0] spec_val;
    logic        sign;
    logic [9:0]  exp;
    logic [26:0] mant;
  } fadd_norm_t;

endpackage
`default_nettype wire

FILE: rtl/chunked_segmented_prefix_sum_core.sv
`default_nettype none
// Chunked segmented prefix sum: per-head fp32 running sums over time-major
// interleaved heads, restarted at each sequence start and every chunk_length
// steps. Sums live in a one-port-read, one-port-write RAM; each beat reads its
// head's sum, passes a three-register fp32 adder and writes back. The result
// passes the RAM data stage, the three adder registers and the output register.
// A beat whose head is still in that read-add-write loop waits. One beat per
// cycle is sustained when head_count is 5 or more and the output is not
// stalled. Valid bits per head make never-written sums read as zero; there is
// no clearing pass after reset.
`include "chunked_segmented_prefix_sum_core_macros.svh"
module chunked_segmented_prefix_sum_core #(
  parameter int unsigned MAX_HEADS = csps_pkg::MaxHeadsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [31:0] value_i,
  input  wire logic        sequence_start_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic      [31:0] running_sum_o
);
  import csps_pkg::*;

  localparam int unsigned HW = (MAX_HEADS > 1) ? $clog2(MAX_HEADS) : 1;

  // Configuration registers
  logic [15:0] chunk_q;
  logic [6:0]  heads_q;
  logic        bf16_q;
  reg_idx_e    ridx;

  assign pready = 1'b1;
  assign ridx   = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_q <= ChunkReset;
      heads_q <= HeadsReset;
      bf16_q  <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (ridx)
        REG_CHUNK: chunk_q <= pwdata[15:0];
        REG_HEADS: heads_q <= pwdata[6:0];
        REG_BF16:  bf16_q  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_CHUNK: prdata = {16'd0, chunk_q};
      REG_HEADS: prdata = {25'd0, heads_q};
      REG_BF16:  prdata = {31'd0, bf16_q};
      default:   prdata = 32'd0;
    endcase
  end

  // Position tracking
  logic [HW-1:0] pos_q, pos_d, h_cur;
  logic [15:0]   step_q, step_d, st_cur;
  logic [HW:0]   heads_eff, h_next;
  logic [16:0]   chunk_eff, step_inc;

  // Pipeline tags: s1 = RAM data stage, t2..t4 = adder registers
  logic          s1_v_q, t2_v_q, t3_v_q, t4_v_q;
  logic [HW-1:0] s1_h_q, t2_h_q, t3_h_q, t4_h_q;
  logic          s1_z_q;
  logic [31:0]   s1_b_q;
  logic [MAX_HEADS-1:0] vld_q;

  logic        advance, conflict, accept;
  logic [31:0] rdata, add_a, add_sum;

  always_comb begin
    h_cur  = sequence_start_i ? '0 : pos_q;
    if ({1'b0, h_cur} >= (HW+1)'(MAX_HEADS)) begin
      h_cur = '0;
    end
    st_cur = sequence_start_i ? 16'd0 : step_q;
    if (heads_q == 7'd0) begin
      heads_eff = (HW+1)'(1);
    end else if (int'(heads_q) > int'(MAX_HEADS)) begin
      heads_eff = (HW+1)'(MAX_HEADS);
    end else begin
      heads_eff = (HW+1)'(heads_q);
    end
    chunk_eff = (chunk_q == 16'd0) ? 17'd1 : {1'b0, chunk_q};
    h_next    = {1'b0, h_cur} + (HW+1)'(1);
    step_inc  = {1'b0, st_cur} + 17'd1;
    if (h_next >= heads_eff) begin
      pos_d  = '0;
      step_d = (step_inc >= chunk_eff) ? 16'd0 : step_inc[15:0];
    end else begin
      pos_d  = h_next[HW-1:0];
      step_d = st_cur;
    end
  end

  // Interlock: the head must not be anywhere in the read-add-write loop
  assign advance  = !out_valid_o || !out_stall_i;
  assign conflict = (s1_v_q && s1_h_q == h_cur) || (t2_v_q && t2_h_q == h_cur) ||
                    (t3_v_q && t3_h_q == h_cur) || (t4_v_q && t4_h_q == h_cur);
  assign in_stall_o = !advance || conflict;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      step_q <= 16'd0;
    end else if (accept) begin
      pos_q  <= pos_d;
      step_q <= step_d;
    end
  end

  // Tag pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      t2_v_q <= 1'b0;
      t3_v_q <= 1'b0;
      t4_v_q <= 1'b0;
    end else if (advance) begin
      s1_v_q <= accept;
      t2_v_q <= s1_v_q;
      t3_v_q <= t2_v_q;
      t4_v_q <= t3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_h_q <= h_cur;
      s1_z_q <= (st_cur == 16'd0) || !vld_q[h_cur];
      s1_b_q <= bf16_q ? {value_i[15:0], 16'd0} : value_i;
      t2_h_q <= s1_h_q;
      t3_h_q <= t2_h_q;
      t4_h_q <= t3_h_q;
    end
  end

  // Written-once marks per head
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (advance && t4_v_q) begin
      vld_q[t4_h_q] <= 1'b1;
    end
  end

  csps_ram #(.Width(32), .Depth(MAX_HEADS), .AddrW(HW)) u_sums (
    .clk_i   (clk_i),
    .we_i    (advance && t4_v_q),
    .waddr_i (t4_h_q),
    .wdata_i (add_sum),
    .re_i    (accept),
    .raddr_i (h_cur),
    .rdata_o (rdata)
  );

  assign add_a = s1_z_q ? FpZero : rdata;

  csps_fadd u_fadd (
    .clk_i (clk_i),
    .en_i  (advance),
    .a_i   (add_a),
    .b_i   (s1_b_q),
    .sum_o (add_sum)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (advance) begin
      out_valid_o <= t4_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && t4_v_q) begin
      running_sum_o <= add_sum;
    end
  end

  `CSPS_ASSERT(a_no_head_overlap, !accept || !(s1_v_q && s1_h_q == h_cur))
  `CSPS_ASSERT(a_no_rw_same_head, !(accept && advance && t4_v_q && t4_h_q == h_cur))
  `CSPS_ASSERT_NEXT(a_result_lands, advance && t4_v_q, out_valid_o)
  `CSPS_ASSERT(a_pos_in_range, {1'b0, pos_q} < (HW+1)'(MAX_HEADS))
endmodule
`default_nettype wire

FILE: rtl/csps_ram.sv
`default_nettype none
module csps_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule
`default_nettype wire

FILE: rtl/csps_fadd.sv
`default_nettype none
// Three-register fp32 adder, round to nearest even. Result is combinational
// from the last register; all registers advance together on en_i.
module csps_fadd (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [31:0] a_i,
  input  wire logic [31:0] b_i,
  output logic      [31:0] sum_o
);
  import csps_pkg::*;

  fadd_swap_t sw_d, sw_q;
  fadd_sum_t  sm_d, sm_q;
  fadd_norm_t nm_d, nm_q;

  // Unpack, special cases, order operands by magnitude
  always_comb begin
    logic a_nan, b_nan, a_inf, b_inf, a_ge;
    logic [23:0] ma, mb;
    logic [7:0]  ea, eb;
    a_nan = (a_i[30:23] == FpExpMax) && (a_i[22:0] != 23'd0);
    b_nan = (b_i[30:23] == FpExpMax) && (b_i[22:0] != 23'd0);
    a_inf = (a_i[30:23] == FpExpMax) && (a_i[22:0] == 23'd0);
    b_inf = (b_i[30:23] == FpExpMax) && (b_i[22:0] == 23'd0);
    ma = {a_i[30:23] != 8'd0, a_i[22:0]};
    mb = {b_i[30:23] != 8'd0, b_i[22:0]};
    ea = (a_i[30:23] == 8'd0) ? 8'd1 : a_i[30:23];
    eb = (b_i[30:23] == 8'd0) ? 8'd1 : b_i[30:23];
    a_ge = a_i[30:0] >= b_i[30:0];
    sw_d.spec = a_nan | b_nan | a_inf | b_inf;
    if (a_nan) begin
      sw_d.spec_val = a_i | FpQuietBit;
    end else if (b_nan) begin
      sw_d.spec_val = b_i | FpQuietBit;
    end else if (a_inf && b_inf && (a_i[31] != b_i[31])) begin
      sw_d.spec_val = FpDefNan;
    end else if (a_inf) begin
      sw_d.spec_val = a_i;
    end else begin
      sw_d.spec_val = b_i;
    end
    sw_d.sub    = a_i[31] ^ b_i[31];
    sw_d.sign   = a_ge ? a_i[31] : b_i[31];
    sw_d.exp    = a_ge ? ea : eb;
    sw_d.mant_l = a_ge ? ma : mb;
    sw_d.mant_s = a_ge ? mb : ma;
    sw_d.diff   = a_ge ? (ea - eb) : (eb - ea);
  end

  // Align smaller operand with sticky, then add or subtract
  always_comb begin
    logic [26:0] ms, sh, al;
    logic        st;
    ms = {sw_q.mant_s, 3'b000};
    sh = ms >> sw_q.diff[4:0];
    st = (sh << sw_q.diff[4:0]) != ms;
    if (sw_q.diff > 8'd26) begin
      al = {26'd0, |sw_q.mant_s};
    end else begin
      al = {sh[26:1], sh[0] | st};
    end
    sm_d.spec     = sw_q.spec;
    sm_d.spec_val = sw_q.spec_val;
    sm_d.sign     = sw_q.sign;
    sm_d.sub      = sw_q.sub;
    sm_d.exp      = sw_q.exp;
    sm_d.sum      = sw_q.sub ? ({1'b0, sw_q.mant_l, 3'b000} - {1'b0, al})
                             : ({1'b0, sw_q.mant_l, 3'b000} + {1'b0, al});
  end

  // Normalize: carry shifts right, cancellation shifts left down to exp 1
  always_comb begin
    logic [4:0] lz, shamt;
    logic [7:0] room;
    lz = 5'd27;
    for (int i = 0; i < 27; i++) begin
      if (sm_q.sum[i]) begin
        lz = 5'(26 - i);
      end
    end
    room  = sm_q.exp - 8'd1;
    shamt = ({3'b000, lz} > room) ? room[4:0] : lz;
    nm_d.spec     = sm_q.spec;
    nm_d.spec_val = sm_q.spec_val;
    if (sm_q.sum == 28'd0) begin
      nm_d.sign = sm_q.sub ? 1'b0 : sm_q.sign;
    end else begin
      nm_d.sign = sm_q.sign;
    end
    if (sm_q.sum[27]) begin
      nm_d.mant = {sm_q.sum[27:2], sm_q.sum[1] | sm_q.sum[0]};
      nm_d.exp  = {2'b00, sm_q.exp} + 10'd1;
    end else begin
      nm_d.mant = sm_q.sum[26:0] << shamt;
      nm_d.exp  = {2'b00, sm_q.exp} - {5'd0, shamt};
    end
  end

  // Round to nearest even and pack
  always_comb begin
    logic        up;
    logic [24:0] m;
    logic [9:0]  e;
    up = nm_q.mant[2] & (nm_q.mant[1] | nm_q.mant[0] | nm_q.mant[3]);
    m  = {1'b0, nm_q.mant[26:3]} + {24'd0, up};
    e  = nm_q.exp;
    if (m[24]) begin
      m = m >> 1;
      e = e + 10'd1;
    end
    if (nm_q.spec) begin
      sum_o = nm_q.spec_val;
    end else if (e >= 10'd255) begin
      sum_o = {nm_q.sign, FpExpMax, 23'd0};
    end else if (!m[23]) begin
      sum_o = {nm_q.sign, 8'd0, m[22:0]};
    end else begin
      sum_o = {nm_q.sign, e[7:0], m[22:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sw_q <= sw_d;
      sm_q <= sm_d;
      nm_q <= nm_d;
    end
  end
endmodule
`default_nettype wire
